[rtl/core/pjc_pkg.sv]
// Package for the parallel printer job controller.
// Holds request and response item types, reply and report codes and status masks.
// No dependencies.
`timescale 1ns / 1ps

package pjc_pkg;

   localparam int unsigned FIELD_COUNT_BITS = 24;
   localparam int unsigned OWNER_BITS = 16;
   localparam logic [7:0] RETRY_RESET = 8'd120;

   localparam logic [7:0] ST_ONLINE = 8'h10;
   localparam logic [7:0] ST_NOPAPER = 8'h20;
   localparam logic [7:0] ST_MASK = 8'hB0;
   localparam logic [7:0] ST_BUSY = 8'h10;
   localparam logic [7:0] ST_NORMAL = 8'h90;

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_POLL   = 3'd1,
      OP_SEND   = 3'd2,
      OP_CANCEL = 3'd3,
      OP_STATUS = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      RPL_ACCEPTED  = 4'd0,
      RPL_BUSY_REJ  = 4'd1,
      RPL_BAD_COUNT = 4'd2,
      RPL_WAITING   = 4'd3,
      RPL_STROBED   = 4'd4,
      RPL_PRN_BUSY  = 4'd5,
      RPL_REPORT    = 4'd6,
      RPL_NO_STATUS = 4'd7,
      RPL_CANCELLED = 4'd8,
      RPL_IGNORED   = 4'd9
   } reply_type;

   typedef enum logic [1:0] {
      FIN_DONE     = 2'd0,
      FIN_IO_ERROR = 2'd1,
      FIN_NO_PAPER = 2'd2,
      FIN_PARTIAL  = 2'd3
   } final_type;

   typedef struct packed {
      logic [2:0]                  op;
      logic [FIELD_COUNT_BITS-1:0] byte_count;
      logic [OWNER_BITS-1:0]       requester_id;
      logic [7:0]                  data_byte;
      logic [7:0]                  printer_status;
   } req_item_type;

   typedef struct packed {
      logic [3:0]                  reply_code;
      logic [7:0]                  port_data;
      logic                        strobe_res;
      logic                        job_finished;
      logic [1:0]                  final_code;
      logic [FIELD_COUNT_BITS-1:0] final_count;
      logic [OWNER_BITS-1:0]       report_requester;
   } rsp_item_type;

endpackage

[rtl/core/pjc_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on pjc_pkg for field widths.
`timescale 1ns / 1ps

interface pjc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [2:0]                            op;
   logic [pjc_pkg::FIELD_COUNT_BITS-1:0]  byte_count;
   logic [pjc_pkg::OWNER_BITS-1:0]        requester_id;
   logic [7:0]                            data_byte;
   logic [7:0]                            printer_status;

   modport source (output valid, op, byte_count, requester_id, data_byte, printer_status,
                   input ready);
   modport sink (input valid, op, byte_count, requester_id, data_byte, printer_status,
                 output ready);
endinterface

interface pjc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [3:0]                            reply_code;
   logic [7:0]                            port_data;
   logic                                  strobe_res;
   logic                                  job_finished;
   logic [1:0]                            final_code;
   logic [pjc_pkg::FIELD_COUNT_BITS-1:0]  final_count;
   logic [pjc_pkg::OWNER_BITS-1:0]        report_requester;

   modport source (output valid, reply_code, port_data, strobe_res, job_finished,
                   final_code, final_count, report_requester, input ready);
   modport sink (input valid, reply_code, port_data, strobe_res, job_finished,
                 final_code, final_count, report_requester, output ready);
endinterface

[rtl/core/pjc_engine.sv]
// Job state and per-request decision logic of the printer job controller.
// Depends on pjc_pkg. Job state advances only on an accepted request.
`timescale 1ns / 1ps

module pjc_engine #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  accept,
   input  pjc_pkg::req_item_type item,
   output pjc_pkg::rsp_item_type result
);

   logic [7:0]            retry_limit_ff;
   logic                  job_active_ff, job_active_in;
   logic                  report_pending_ff, report_pending_in;
   logic                  online_seen_ff, online_seen_in;
   logic [COUNT_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [COUNT_BITS-1:0] bytes_total_ff, bytes_total_in;
   logic [7:0]            retries_left_ff, retries_left_in;
   logic [pjc_pkg::OWNER_BITS-1:0] job_owner_ff, job_owner_in;
   logic [1:0]            pending_code_ff, pending_code_in;
   logic [COUNT_BITS-1:0] pending_count_ff, pending_count_in;

   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] printed;
   logic [COUNT_BITS-1:0] left_dec;
   logic [7:0]            masked;
   logic                  finish;
   logic [1:0]            fin_code;
   logic [COUNT_BITS-1:0] fin_count;

   assign cnt      = COUNT_BITS'(item.byte_count);
   assign printed  = bytes_total_ff - bytes_left_ff;
   assign left_dec = bytes_left_ff - COUNT_BITS'(1);
   assign masked   = item.printer_status & pjc_pkg::ST_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= pjc_pkg::RETRY_RESET;
      end else if (csr_wr_en) begin
         retry_limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      job_active_in     = job_active_ff;
      report_pending_in = report_pending_ff;
      online_seen_in    = online_seen_ff;
      bytes_left_in     = bytes_left_ff;
      bytes_total_in    = bytes_total_ff;
      retries_left_in   = retries_left_ff;
      job_owner_in      = job_owner_ff;
      finish            = 1'b0;
      fin_code          = pjc_pkg::FIN_DONE;
      fin_count         = '0;
      result            = '0;
      result.reply_code = pjc_pkg::RPL_IGNORED;

      case (item.op)
         pjc_pkg::OP_START: begin
            if (job_active_ff) begin
               result.reply_code = pjc_pkg::RPL_BUSY_REJ;
            end else if (cnt == '0) begin
               result.reply_code = pjc_pkg::RPL_BAD_COUNT;
            end else begin
               job_active_in     = 1'b1;
               report_pending_in = 1'b0;
               online_seen_in    = 1'b0;
               job_owner_in      = item.requester_id;
               bytes_left_in     = cnt;
               bytes_total_in    = cnt;
               retries_left_in   = retry_limit_ff;
               result.reply_code = pjc_pkg::RPL_ACCEPTED;
            end
         end
         pjc_pkg::OP_POLL: begin
            if (job_active_ff && !online_seen_ff && !report_pending_ff) begin
               if ((item.printer_status & pjc_pkg::ST_ONLINE) != 8'd0) begin
                  online_seen_in    = 1'b1;
                  result.reply_code = pjc_pkg::RPL_ACCEPTED;
               end else begin
                  result.reply_code = pjc_pkg::RPL_WAITING;
                  if (retries_left_ff <= 8'd1) begin
                     retries_left_in = 8'd0;
                     finish          = 1'b1;
                     fin_code        = pjc_pkg::FIN_IO_ERROR;
                  end else begin
                     retries_left_in = retries_left_ff - 8'd1;
                  end
               end
            end
         end
         pjc_pkg::OP_SEND: begin
            if (job_active_ff && online_seen_ff && !report_pending_ff &&
                bytes_left_ff != '0) begin
               if (masked == pjc_pkg::ST_BUSY) begin
                  result.reply_code = pjc_pkg::RPL_PRN_BUSY;
               end else if (masked == pjc_pkg::ST_NORMAL) begin
                  result.reply_code = pjc_pkg::RPL_STROBED;
                  result.port_data  = item.data_byte;
                  result.strobe_res = 1'b1;
                  bytes_left_in     = left_dec;
                  if (left_dec == '0) begin
                     finish    = 1'b1;
                     fin_code  = pjc_pkg::FIN_DONE;
                     fin_count = bytes_total_ff;
                  end
               end else begin
                  result.reply_code = pjc_pkg::RPL_WAITING;
                  finish            = 1'b1;
                  // paper-out only counts while the select line is up
                  if ((item.printer_status & pjc_pkg::ST_ONLINE) != 8'd0 &&
                      (item.printer_status & pjc_pkg::ST_NOPAPER) != 8'd0) begin
                     if (printed != '0) begin
                        fin_code  = pjc_pkg::FIN_PARTIAL;
                        fin_count = printed;
                     end else begin
                        fin_code  = pjc_pkg::FIN_NO_PAPER;
                     end
                  end else begin
                     fin_code = pjc_pkg::FIN_IO_ERROR;
                  end
               end
            end
         end
         pjc_pkg::OP_CANCEL: begin
            if (job_active_ff && item.requester_id == job_owner_ff) begin
               job_active_in     = 1'b0;
               report_pending_in = 1'b0;
               online_seen_in    = 1'b0;
               result.reply_code = pjc_pkg::RPL_CANCELLED;
            end
         end
         pjc_pkg::OP_STATUS: begin
            if (report_pending_ff) begin
               result.reply_code       = pjc_pkg::RPL_REPORT;
               result.final_code       = pending_code_ff;
               result.final_count      = pjc_pkg::FIELD_COUNT_BITS'(pending_count_ff);
               result.report_requester = job_owner_ff;
               report_pending_in       = 1'b0;
               job_active_in           = 1'b0;
               online_seen_in          = 1'b0;
            end else begin
               result.reply_code = pjc_pkg::RPL_NO_STATUS;
            end
         end
         default: begin
         end
      endcase

      pending_code_in  = pending_code_ff;
      pending_count_in = pending_count_ff;
      if (finish) begin
         report_pending_in       = 1'b1;
         pending_code_in         = fin_code;
         pending_count_in        = fin_count;
         result.job_finished     = 1'b1;
         result.final_code       = fin_code;
         result.final_count      = pjc_pkg::FIELD_COUNT_BITS'(fin_count);
         result.report_requester = job_owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff     <= 1'b0;
         report_pending_ff <= 1'b0;
         online_seen_ff    <= 1'b0;
         bytes_left_ff     <= '0;
         bytes_total_ff    <= '0;
         retries_left_ff   <= 8'd0;
         job_owner_ff      <= '0;
         pending_code_ff   <= 2'd0;
         pending_count_ff  <= '0;
      end else if (accept) begin
         job_active_ff     <= job_active_in;
         report_pending_ff <= report_pending_in;
         online_seen_ff    <= online_seen_in;
         bytes_left_ff     <= bytes_left_in;
         bytes_total_ff    <= bytes_total_in;
         retries_left_ff   <= retries_left_in;
         job_owner_ff      <= job_owner_in;
         pending_code_ff   <= pending_code_in;
         pending_count_ff  <= pending_count_in;
      end
   end

endmodule

[rtl/core/pjc_out_reg.sv]
// Response output register with valid/ready flow control.
// Depends on pjc_pkg for the response item type.
`timescale 1ns / 1ps

module pjc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pjc_pkg::rsp_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pjc_pkg::rsp_item_type out_item
);

   logic                  valid_ff, valid_in;
   pjc_pkg::rsp_item_type item_ff;

   // take a new response whenever the slot is empty or drains this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

[rtl/core/parallel_printer_job_controller_top.sv]
// Parallel printer job controller: one response per request, one request per cycle unless the response side stalls.
// Channels use a valid/ready handshake on the req and rsp interfaces; a request is taken
// when valid and ready are both high at a rising clock edge.
// csr_wr_en/csr_wr_data write the online retry limit (reset value 120); write it only
// while no request is outstanding.
// The response for a request is valid on the cycle after it is accepted.
// One request per cycle while the receiver keeps taking responses. All decisions are a few
// compares and one counter update on the job registers, finished in the accept cycle, with
// the response held in a single output register.
// When the receiver stalls, the response holds in the output register and req ready
// drops until it is taken; ready stays high when the output drains in the same cycle.
// Reset (synchronous, active high) clears the job state, drops any pending report and
// empties the output register; the retry limit returns to 120.
// COUNT_BITS sets the width of the internal byte counters; counts are shown in the 24-bit
// response fields.
// Depends on pjc_pkg, pjc_if, pjc_engine and pjc_out_reg.
`timescale 1ns / 1ps

module parallel_printer_job_controller_top #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   pjc_req_if.sink    req_ch,
   pjc_rsp_if.source  rsp_ch
);

   pjc_pkg::req_item_type req_item;
   pjc_pkg::rsp_item_type eng_result;
   pjc_pkg::rsp_item_type rsp_item;
   logic                  req_ready;
   logic                  accept;

   assign req_item.op             = req_ch.op;
   assign req_item.byte_count     = req_ch.byte_count;
   assign req_item.requester_id   = req_ch.requester_id;
   assign req_item.data_byte      = req_ch.data_byte;
   assign req_item.printer_status = req_ch.printer_status;

   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;

   pjc_engine #(
      .COUNT_BITS(COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .accept     (accept),
      .item       (req_item),
      .result     (eng_result)
   );

   pjc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_item  (eng_result),
      .in_ready (req_ready),
      .out_valid(rsp_ch.valid),
      .out_ready(rsp_ch.ready),
      .out_item (rsp_item)
   );

   assign rsp_ch.reply_code       = rsp_item.reply_code;
   assign rsp_ch.port_data        = rsp_item.port_data;
   assign rsp_ch.strobe_res       = rsp_item.strobe_res;
   assign rsp_ch.job_finished     = rsp_item.job_finished;
   assign rsp_ch.final_code       = rsp_item.final_code;
   assign rsp_ch.final_count      = rsp_item.final_count;
   assign rsp_ch.report_requester = rsp_item.report_requester;

endmodule
